// ===== hdl/point_mass_gravity_accel_macros.svh =====
`ifndef POINT_MASS_GRAVITY_ACCEL_MACROS_SVH
`define POINT_MASS_GRAVITY_ACCEL_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PMGA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PMGA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pmga_pkg.sv =====
`timescale 1ns / 1ps
package pmga_pkg;

  localparam int POS_W      = 31;
  localparam int MAG_W      = 31;
  localparam int SQR_W      = 2 * MAG_W;
  localparam int SUM_W      = 62;
  localparam int ROOT_W     = 47;
  localparam int ROOT_FRAC  = 16;
  localparam int REM_W      = ROOT_W + 3;
  localparam int NRAD_W     = 2 * ROOT_W;
  localparam int GRAV_W     = 50;
  localparam int GLO_W      = 25;
  localparam int SLO_W      = 31;
  localparam int QLO_W      = 24;
  localparam int PD_W       = SLO_W + QLO_W;
  localparam int PN_W       = GLO_W + MAG_W;
  localparam int PROD_W     = GRAV_W + MAG_W;
  localparam int DEN_W      = 109;
  localparam int QUO_W      = 32;
  localparam int ACC_W      = 32;
  localparam int CMP_W      = DEN_W + QUO_W;

  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STAGES = QUO_W + 1;
  localparam int ST_SUM     = 2;
  localparam int ST_PART    = ST_SUM + SQRT_STEPS + 1;
  localparam int ST_NUM     = ST_PART + 1;
  localparam int ST_DIV0    = ST_NUM + 1;
  localparam int ST_OUT     = ST_DIV0 + DIV_STAGES;
  localparam int N_STAGES   = ST_OUT + 1;

  localparam logic [GRAV_W-1:0] GRAV_RESET  = 50'd398600441800000;
  localparam logic [ACC_W-1:0]  ACC_POS_LIM = 32'h7FFF_FFFF;
  localparam logic [ACC_W-1:0]  ACC_NEG_LIM = 32'h8000_0000;

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic [SUM_W-1:0]  s;
    mag_t [2:0]        mag;
    logic [2:0]        neg;
    logic              zero;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [NRAD_W-1:0] nrad;
  } sqrt_stage_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } side_t;

  typedef struct packed {
    logic [ACC_W-1:0] val;
    logic             sat;
  } axis_out_t;

  function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t a);
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] t;
    sqrt_stage_t      b;
    b = a;
    r = {a.rem[REM_W-3:0], a.nrad[NRAD_W-1 -: 2]};
    t = REM_W'({a.root, 2'b01});
    b.nrad = a.nrad << 2;
    if (r >= t) begin
      b.rem  = r - t;
      b.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem  = r;
      b.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return b;
  endfunction

  function automatic axis_out_t clip_axis(input logic neg, input logic ovf,
                                          input logic [QUO_W-1:0] quo);
    axis_out_t o;
    if (neg) begin
      if (ovf || quo > ACC_POS_LIM) begin
        o.val = ACC_POS_LIM;
        o.sat = 1'b1;
      end else begin
        o.val = quo;
        o.sat = 1'b0;
      end
    end else begin
      if (ovf || quo > ACC_NEG_LIM) begin
        o.val = ACC_NEG_LIM;
        o.sat = 1'b1;
      end else begin
        o.val = ~quo + 32'd1;
        o.sat = 1'b0;
      end
    end
    return o;
  endfunction

endpackage

// ===== hdl/pmga_ifs.sv =====
`timescale 1ns / 1ps
interface pmga_pos_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] pos_x;
  logic signed [30:0] pos_y;
  logic signed [30:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface pmga_acc_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic signed [31:0] acc_z;
  logic               saturated;

  modport source (output valid, output acc_x, output acc_y, output acc_z,
                  output saturated, input ready);
  modport sink (input valid, input acc_x, input acc_y, input acc_z,
                input saturated, output ready);
endinterface

// ===== hdl/pmga_div.sv =====
`timescale 1ns / 1ps
module pmga_div (
  input  logic                                 clk,
  input  logic [pmga_pkg::DIV_STAGES-1:0]      en,
  input  logic [pmga_pkg::CMP_W-1:0]           num,
  input  logic [pmga_pkg::DEN_W-1:0]           den,
  output logic [pmga_pkg::QUO_W-1:0]           quo,
  output logic                                 ovf
);
  import pmga_pkg::*;

  logic [CMP_W-1:0] rem   [DIV_STAGES];
  logic [DEN_W-1:0] dq    [DIV_STAGES];
  logic [QUO_W-1:0] qbits [DIV_STAGES];
  logic             oflag [DIV_STAGES];

  // The quotient is known to fit in QUO_W bits unless the first compare trips.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]   <= num;
      dq[0]    <= den;
      qbits[0] <= '0;
      oflag[0] <= num >= {den, {QUO_W{1'b0}}};
    end
  end

  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_step
    logic [CMP_W-1:0] trial;
    assign trial = CMP_W'(dq[j-1]) << (QUO_W - j);
    always_ff @(posedge clk) begin
      if (en[j]) begin
        dq[j]    <= dq[j-1];
        oflag[j] <= oflag[j-1];
        if (rem[j-1] >= trial) begin
          rem[j]   <= rem[j-1] - trial;
          qbits[j] <= qbits[j-1] | (QUO_W'(1) << (QUO_W - j));
        end else begin
          rem[j]   <= rem[j-1];
          qbits[j] <= qbits[j-1];
        end
      end
    end
  end

  assign quo = qbits[DIV_STAGES-1];
  assign ovf = oflag[DIV_STAGES-1];
endmodule

// ===== hdl/point_mass_gravity_accel.sv =====
`timescale 1ns / 1ps
// Point-mass gravity: a = -GM * p / |p|^3 on three axes.
// The pos channel takes one position beat (pos_x, pos_y, pos_z, whole meters).
// The acc channel returns one beat per position: acc_x, acc_y, acc_z with
// ACCEL_FRAC_BITS fraction bits, and saturated when the radius was zero or a
// component clipped. Both channels use a valid/ready handshake.
// GM is written through cfg_we/cfg_wdata by the user, only while the block
// is idle; the block does not enforce this. A beat accepted on pos passes
// through all 86 register stages to acc. The square root takes one stage per
// result bit (47) and each of the three dividers an overflow stage plus one
// stage per quotient bit (33 in all), so one beat can enter every cycle when
// nothing stalls. Each stage holds a valid bit and loads when it is empty or
// its content moves on, so bubbles close up and pos stays ready while a
// finished beat waits on a stalled receiver until the whole pipeline is full.
// A synchronous reset empties the pipeline and sets GM to 398600441800000.
module point_mass_gravity_accel #(
  parameter int ACCEL_FRAC_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pmga_pkg::GRAV_W-1:0]   cfg_wdata,
  pmga_pos_if.sink                      pos,
  pmga_acc_if.source                    acc
);
  import pmga_pkg::*;

  localparam int SHIFT = ACCEL_FRAC_BITS + ROOT_FRAC;

  logic [GRAV_W-1:0]   grav;
  logic [N_STAGES-1:0] v;
  logic [N_STAGES-1:0] v_next;
  logic [N_STAGES-1:0] en;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav <= GRAV_RESET;
    end else if (cfg_we) begin
      grav <= cfg_wdata;
    end
  end

  assign en[N_STAGES-1] = !v[N_STAGES-1] || acc.ready;
  for (genvar i = 0; i < N_STAGES - 1; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end

  assign v_next = {v[N_STAGES-2:0], pos.valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < N_STAGES; i++) begin
        if (en[i]) begin
          v[i] <= v_next[i];
        end
      end
    end
  end

  assign pos.ready = en[0];

  logic [POS_W-1:0] pin [3];
  assign pin[0] = pos.pos_x;
  assign pin[1] = pos.pos_y;
  assign pin[2] = pos.pos_z;

  mag_t       mag0 [3];
  logic [2:0] neg0;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        neg0[k] <= pin[k][POS_W-1];
        mag0[k] <= pin[k][POS_W-1] ? (~pin[k] + MAG_W'(1)) : pin[k];
      end
    end
  end

  logic [SQR_W-1:0] sqr1 [3];
  mag_t             mag1 [3];
  logic [2:0]       neg1;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        sqr1[k] <= mag0[k] * mag0[k];
        mag1[k] <= mag0[k];
      end
      neg1 <= neg0;
    end
  end

  logic [SUM_W-1:0] ssum;
  assign ssum = SUM_W'(sqr1[0]) + SUM_W'(sqr1[1]) + SUM_W'(sqr1[2]);

  sqrt_stage_t sq [SQRT_STEPS+1];
  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      sq[0].s      <= ssum;
      sq[0].mag    <= {mag1[2], mag1[1], mag1[0]};
      sq[0].neg    <= neg1;
      sq[0].zero   <= ssum == '0;
      sq[0].rem    <= '0;
      sq[0].root   <= '0;
      sq[0].nrad   <= {ssum, {(NRAD_W-SUM_W){1'b0}}};
    end
  end

  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (en[ST_SUM+k]) begin
        sq[k] <= sqrt_step(sq[k-1]);
      end
    end
  end

  sqrt_stage_t last;
  assign last = sq[SQRT_STEPS];

  logic [PD_W-1:0] pd [4];
  logic [PN_W-1:0] pn_lo [3];
  logic [PN_W-1:0] pn_hi [3];
  side_t           side_p;
  always_ff @(posedge clk) begin
    if (en[ST_PART]) begin
      pd[0] <= PD_W'(last.s[SLO_W-1:0]) * PD_W'(last.root[QLO_W-1:0]);
      pd[1] <= PD_W'(last.s[SLO_W-1:0]) * PD_W'(last.root[ROOT_W-1:QLO_W]);
      pd[2] <= PD_W'(last.s[SUM_W-1:SLO_W]) * PD_W'(last.root[QLO_W-1:0]);
      pd[3] <= PD_W'(last.s[SUM_W-1:SLO_W]) * PD_W'(last.root[ROOT_W-1:QLO_W]);
      for (int k = 0; k < 3; k++) begin
        pn_lo[k] <= grav[GLO_W-1:0] * last.mag[k];
        pn_hi[k] <= grav[GRAV_W-1:GLO_W] * last.mag[k];
      end
      side_p.neg  <= last.neg;
      side_p.zero <= last.zero;
    end
  end

  logic [DEN_W-1:0]  den;
  logic [PROD_W-1:0] prod [3];
  side_t             side_n;
  always_ff @(posedge clk) begin
    if (en[ST_NUM]) begin
      den <= DEN_W'(pd[0]) + (DEN_W'(pd[1]) << QLO_W) + (DEN_W'(pd[2]) << SLO_W)
           + (DEN_W'(pd[3]) << (SLO_W + QLO_W));
      for (int k = 0; k < 3; k++) begin
        prod[k] <= PROD_W'(pn_lo[k]) + (PROD_W'(pn_hi[k]) << GLO_W);
      end
      side_n <= side_p;
    end
  end

  logic [QUO_W-1:0] quo [3];
  logic             ovf [3];
  for (genvar k = 0; k < 3; k++) begin : g_div
    pmga_div u_div (
      .clk (clk),
      .en  (en[ST_DIV0 +: DIV_STAGES]),
      .num (CMP_W'(prod[k]) << SHIFT),
      .den (den),
      .quo (quo[k]),
      .ovf (ovf[k])
    );
  end

  side_t side_d [DIV_STAGES];
  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (en[ST_DIV0+j]) begin
        side_d[j] <= (j == 0) ? side_n : side_d[(j == 0) ? 0 : j - 1];
      end
    end
  end

  side_t     side_o;
  axis_out_t ax [3];
  assign side_o = side_d[DIV_STAGES-1];
  for (genvar k = 0; k < 3; k++) begin : g_clip
    assign ax[k] = clip_axis(side_o.neg[k], ovf[k], quo[k]);
  end

  logic [ACC_W-1:0] acc_r [3];
  logic             sat_r;
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      if (side_o.zero) begin
        acc_r[0] <= '0;
        acc_r[1] <= '0;
        acc_r[2] <= '0;
        sat_r    <= 1'b1;
      end else begin
        acc_r[0] <= ax[0].val;
        acc_r[1] <= ax[1].val;
        acc_r[2] <= ax[2].val;
        sat_r    <= ax[0].sat | ax[1].sat | ax[2].sat;
      end
    end
  end

  assign acc.valid     = v[ST_OUT];
  assign acc.acc_x     = acc_r[0];
  assign acc.acc_y     = acc_r[1];
  assign acc.acc_z     = acc_r[2];
  assign acc.saturated = sat_r;
endmodule

// ===== hdl/pmga_chk.sv =====
`timescale 1ns / 1ps
`include "point_mass_gravity_accel_macros.svh"
module pmga_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         acc_valid,
  input logic                         acc_ready,
  input logic [pmga_pkg::ACC_W-1:0]   acc_x,
  input logic [pmga_pkg::ACC_W-1:0]   acc_y,
  input logic [pmga_pkg::ACC_W-1:0]   acc_z,
  input logic                         saturated
);
  import pmga_pkg::*;

  `PMGA_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !acc_valid, "acc valid after reset")
  `PMGA_ASSERT(a_valid_holds, clk, rst, acc_valid && !acc_ready |=> acc_valid, "acc beat dropped")
  `PMGA_ASSERT(a_beat_stable, clk, rst, acc_valid && !acc_ready |=> $stable(acc_x) && $stable(acc_y) && $stable(acc_z) && $stable(saturated), "acc beat changed under stall")
  `PMGA_ASSERT(a_sat_shape, clk, rst, acc_valid && saturated |-> (acc_x == '0 && acc_y == '0 && acc_z == '0) || acc_x == ACC_POS_LIM || acc_x == ACC_NEG_LIM || acc_y == ACC_POS_LIM || acc_y == ACC_NEG_LIM || acc_z == ACC_POS_LIM || acc_z == ACC_NEG_LIM, "saturated without a clipped or zero result")
endmodule

bind point_mass_gravity_accel pmga_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .acc_valid (acc.valid),
  .acc_ready (acc.ready),
  .acc_x     (acc.acc_x),
  .acc_y     (acc.acc_y),
  .acc_z     (acc.acc_z),
  .saturated (acc.saturated)
);

// ===== dv/point_mass_gravity_accel_test.sv =====
`timescale 1ns / 1ps
module point_mass_gravity_accel_test;
  import pmga_pkg::*;

  localparam int FRAC = 24;
  localparam logic [GRAV_W-1:0] GM_MAX = {GRAV_W{1'b1}};
  localparam logic [GRAV_W-1:0] GM_MOON = 50'd4904869500000;

  typedef struct packed {
    logic [ACC_W-1:0] ax;
    logic [ACC_W-1:0] ay;
    logic [ACC_W-1:0] az;
    logic             sat;
  } accel_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [GRAV_W-1:0] cfg_wdata = '0;

  pmga_pos_if pos ();
  pmga_acc_if acc ();

  point_mass_gravity_accel #(.ACCEL_FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .pos(pos), .acc(acc)
  );

  always #5 clk = ~clk;

  logic [GRAV_W-1:0] gm_now = GRAV_RESET;
  accel_beat_t expected_accel[$];
  int mismatches = 0;
  int stall_len = 0;
  logic stall_kick = 1'b0;

  function automatic accel_beat_t gravity_accel(input logic [POS_W-1:0] px, py, pz,
                                                input logic [GRAV_W-1:0] gm);
    logic [POS_W-1:0] p[3];
    logic [31:0] mag[3];
    logic [63:0] s;
    logic [95:0] n;
    logic [46:0] q;
    logic [46:0] c;
    logic [127:0] den;
    logic [127:0] num;
    logic [127:0] quo;
    logic [ACC_W-1:0] a[3];
    accel_beat_t r;
    p[0] = px; p[1] = py; p[2] = pz;
    s = '0;
    r.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = p[i][30] ? (32'h8000_0000 - {1'b0, p[i]}) : {1'b0, p[i]};
      s = s + 64'(mag[i]) * 64'(mag[i]);
    end
    if (s == 0) begin
      r.ax = '0; r.ay = '0; r.az = '0; r.sat = 1'b1;
      return r;
    end
    n = {s, 32'b0};
    q = '0;
    for (int b = 46; b >= 0; b--) begin
      c = q | (47'd1 << b);
      if (96'(c) * 96'(c) <= n) q = c;
    end
    den = 128'(s) * 128'(q);
    for (int i = 0; i < 3; i++) begin
      num = (128'(gm) * 128'(mag[i])) << (FRAC + ROOT_FRAC);
      quo = num / den;
      if (p[i][30]) begin
        if (quo > 128'h7FFF_FFFF) begin
          a[i] = ACC_POS_LIM; r.sat = 1'b1;
        end else begin
          a[i] = quo[31:0];
        end
      end else begin
        if (quo > 128'h8000_0000) begin
          a[i] = ACC_NEG_LIM; r.sat = 1'b1;
        end else begin
          a[i] = -quo[31:0];
        end
      end
    end
    r.ax = a[0]; r.ay = a[1]; r.az = a[2];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got, exp);
    $display("mismatch on %s: got %h, expected %h at %0t", what, got, exp, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    accel_beat_t e;
    if (!rst && acc.valid && acc.ready) begin
      if (expected_accel.size() == 0) begin
        report_mismatch("unexpected beat", {acc.acc_x, acc.acc_y}, '0);
      end else begin
        e = expected_accel.pop_front();
        if (acc.acc_x !== e.ax) report_mismatch("acc_x", acc.acc_x, e.ax);
        if (acc.acc_y !== e.ay) report_mismatch("acc_y", acc.acc_y, e.ay);
        if (acc.acc_z !== e.az) report_mismatch("acc_z", acc.acc_z, e.az);
        if (acc.saturated !== e.sat) report_mismatch("saturated", acc.saturated, e.sat);
      end
    end
  end

  initial begin
    int hold;
    int pct;
    int left;
    logic last_kick;
    hold = 0; pct = 100; left = 0; last_kick = 1'b0;
    acc.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_kick != last_kick) begin
        last_kick = stall_kick;
        hold = stall_len;
      end
      if (left == 0) begin
        left = $urandom_range(20, 300);
        case ($urandom_range(0, 3))
          0: pct = 100;
          1: pct = 80;
          2: pct = 50;
          default: pct = 15;
        endcase
      end
      left--;
      if (hold > 0) begin
        hold--;
        acc.ready <= 1'b0;
      end else begin
        acc.ready <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin
    pos.valid = 1'b0;
    pos.pos_x = '0;
    pos.pos_y = '0;
    pos.pos_z = '0;
  end

  task automatic send_pos(input logic [POS_W-1:0] px, py, pz);
    pos.valid <= 1'b1;
    pos.pos_x <= px;
    pos.pos_y <= py;
    pos.pos_z <= pz;
    @(posedge clk);
    while (!pos.ready) @(posedge clk);
    expected_accel = {expected_accel, gravity_accel(px, py, pz, gm_now)};
  endtask

  task automatic pause_pos(input int cycles);
    pos.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain;
    pause_pos(1);
    while (expected_accel.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_gm(input logic [GRAV_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    gm_now = v;
  endtask

  function automatic logic [POS_W-1:0] orbit_coord();
    int unsigned m;
    m = $urandom_range(0, 45000000);
    return $urandom_range(0, 1) ? POS_W'(-m) : POS_W'(m);
  endfunction

  function automatic logic [POS_W-1:0] any_coord();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 3))
      0: return r[POS_W-1:0];
      1: return orbit_coord();
      2: return POS_W'($signed(r[7:0]));
      default: return {r[0], {(POS_W-1){~r[0]}}};
    endcase
  endfunction

  task automatic test_directed_extremes;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    lo = {1'b1, {(POS_W-1){1'b0}}};
    hi = {1'b0, {(POS_W-1){1'b1}}};
    send_pos('0, '0, '0);
    send_pos(lo, lo, lo);
    send_pos(hi, hi, hi);
    send_pos(lo, '0, '0);
    send_pos('0, hi, '0);
    send_pos('0, '0, lo);
    send_pos(31'd1, '0, '0);
    send_pos('1, '0, '0);
    send_pos('0, '0, 31'd1);
    send_pos(31'd6378137, '0, '0);
    send_pos('0, -31'd6378137, '0);
    send_pos(31'd3000, -31'd4000, 31'd5000);
    send_pos(31'd42164000, 31'd1, -31'd1);
    send_pos(lo, hi, '1);
    drain();
  endtask

  task automatic test_zero_gm;
    write_gm('0);
    send_pos('0, '0, '0);
    send_pos(31'd1, '1, 31'd2);
    send_pos(31'd7000000, '0, -31'd7000000);
    drain();
  endtask

  task automatic test_max_gm;
    write_gm(GM_MAX);
    send_pos({1'b1, 30'b0}, '0, '0);
    send_pos({1'b0, {30{1'b1}}}, {1'b0, {30{1'b1}}}, '0);
    send_pos(31'd100000, '0, '0);
    drain();
  endtask

  task automatic test_random_stream(input logic [GRAV_W-1:0] gm, input int items);
    int burst;
    write_gm(gm);
    burst = 0;
    for (int i = 0; i < items; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) pause_pos($urandom_range(1, 12));
      end
      burst--;
      send_pos(any_coord(), any_coord(), any_coord());
    end
    drain();
  endtask

  task automatic test_backpressure;
    write_gm(GRAV_RESET);
    stall_len = 400;
    stall_kick <= ~stall_kick;
    for (int i = 0; i < 250; i++) send_pos(orbit_coord(), orbit_coord(), orbit_coord());
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_zero_gm();
    test_max_gm();
    test_random_stream(GRAV_RESET, 400);
    test_random_stream(GM_MAX, 300);
    test_random_stream('0, 200);
    test_random_stream(GM_MOON, 300);
    test_random_stream(GRAV_W'({$urandom(), $urandom()} >> 14), 400);
    test_backpressure();
    if (mismatches == 0) begin
      $display("point_mass_gravity_accel test passed");
    end else begin
      $display("point_mass_gravity_accel test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("point_mass_gravity_accel test failed");
    $finish;
  end

endmodule

// ===== point_mass_gravity_accel.f =====
+incdir+hdl
hdl/pmga_pkg.sv
hdl/pmga_ifs.sv
hdl/pmga_div.sv
hdl/point_mass_gravity_accel.sv
hdl/pmga_chk.sv
dv/point_mass_gravity_accel_test.sv
